/* rtl/bcpu_pkg.sv */
// package: shared widths, codes and types of the byte processor
package bcpu_pkg;

    localparam int BYTE_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int ADDR_W     = 9;
    localparam int FLAG_W     = 2;
    localparam int GPR_DEPTH  = 8;
    localparam int GPR_IDX_W  = 3;
    localparam int PC_STEP    = 3;
    localparam int BASE_RESET = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    // function codes of an input word
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_MEM = 2'd0,
        FUNC_STEP      = 2'd1,
        FUNC_READ_REG  = 2'd2,
        FUNC_READ_MEM  = 2'd3
    } t_func;

    // register indexes
    localparam t_byte REG_PC        = 8'd0;
    localparam t_byte REG_SP        = 8'd1;
    localparam t_byte REG_GPR_FIRST = 8'd2;
    localparam t_byte REG_GPR_LAST  = 8'd9;
    localparam t_byte REG_ACC       = 8'd10;
    localparam t_byte REG_FLAG      = 8'd11;
    localparam t_byte REG_NONE      = 8'hFF;

    // compare flag values
    localparam t_byte FLAG_EQ = 8'd0;
    localparam t_byte FLAG_GT = 8'd1;
    localparam t_byte FLAG_LT = 8'd2;

    // opcodes
    localparam t_byte OP_NOP   = 8'd0;
    localparam t_byte OP_COPY  = 8'd1;
    localparam t_byte OP_STORE = 8'd2;
    localparam t_byte OP_LOAD  = 8'd3;
    localparam t_byte OP_IMM   = 8'd4;
    localparam t_byte OP_INC   = 8'd5;
    localparam t_byte OP_DEC   = 8'd6;
    localparam t_byte OP_ADD   = 8'd7;
    localparam t_byte OP_SUB   = 8'd8;
    localparam t_byte OP_MUL   = 8'd9;
    localparam t_byte OP_DIV   = 8'd10;
    localparam t_byte OP_PUSH  = 8'd11;
    localparam t_byte OP_POP   = 8'd12;
    localparam t_byte OP_CALL  = 8'd13;
    localparam t_byte OP_RCALL = 8'd14;
    localparam t_byte OP_RET   = 8'd15;
    localparam t_byte OP_CMP   = 8'd16;
    localparam t_byte OP_JMP   = 8'd17;
    localparam t_byte OP_JEQ   = 8'd18;
    localparam t_byte OP_JLT   = 8'd19;
    localparam t_byte OP_JGT   = 8'd20;
    localparam t_byte OP_JNE   = 8'd21;
    localparam t_byte OP_HALT  = 8'd22;
    localparam t_byte OP_OUT   = 8'd23;
    localparam t_byte OP_IN    = 8'd24;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH1,
        ST_FETCH2,
        ST_FETCH3,
        ST_EXEC,
        ST_WBACK
    } t_state;

endpackage

/* rtl/bcpu_item_if.sv */
// interface: input word channel of the byte processor
interface bcpu_item_if;
    logic                          valid;
    logic                          ready;
    bcpu_pkg::t_func               func;
    logic [bcpu_pkg::ADDR_W-1:0]   address;
    logic [bcpu_pkg::BYTE_W-1:0]   data;

    modport source (output valid, output func, output address, output data, input ready);
    modport sink   (input valid, input func, input address, input data, output ready);
endinterface

/* rtl/bcpu_result_if.sv */
// interface: result word channel of the byte processor
interface bcpu_result_if;
    logic                          valid;
    logic                          ready;
    logic [bcpu_pkg::BYTE_W-1:0]   read_data;
    logic [bcpu_pkg::BYTE_W-1:0]   pc_value;
    logic [bcpu_pkg::BYTE_W-1:0]   sp_value;
    logic [bcpu_pkg::BYTE_W-1:0]   accumulator;
    logic [bcpu_pkg::FLAG_W-1:0]   compare_flag;
    logic [bcpu_pkg::BYTE_W-1:0]   opcode_done;
    logic                          halted;

    modport source (output valid, output read_data, output pc_value, output sp_value,
                    output accumulator, output compare_flag, output opcode_done,
                    output halted, input ready);
    modport sink   (input valid, input read_data, input pc_value, input sp_value,
                    input accumulator, input compare_flag, input opcode_done,
                    input halted, output ready);
endinterface

/* rtl/byte_cpu_fetch_execute_core.sv */
// top level: byte processor with single-port data memory and sequenced fetch/execute
//
// Memory write, memory read and register read words are taken one per cycle while idle
// and the pending stage is empty or draining; each gives its result word through a
// pending stage and an output register, so the next word can be taken while a result
// waits. A step word runs through the fetch states and execute, and load, pop and
// return add a write-back state: the single data memory port does three instruction
// byte reads and then one data access, and the general register file reads the second
// operand in a further state. After reset a clearing pass zeroes the data memory,
// during which no word is accepted; program_base can be written at any time.
module byte_cpu_fetch_execute_core #(
    parameter int MEM_DEPTH = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bcpu_pkg::BYTE_W-1:0]   i_cfg_wr_data,
    bcpu_item_if.sink                     i_item,
    bcpu_result_if.source                 o_result
);
    import bcpu_pkg::*;

    localparam int AW    = $clog2(MEM_DEPTH);
    localparam int SUM_W = ((AW > ADDR_W + 1) ? AW : ADDR_W + 1) + 1;
    localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(MEM_DEPTH);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(MEM_DEPTH - 1);

    // wrap an address that stays below twice the depth
    function automatic logic [AW-1:0] wrap_addr(input logic [SUM_W-1:0] a);
        logic [SUM_W-1:0] w;
        w = (a >= DEPTH_S) ? (a - DEPTH_S) : a;
        return AW'(w);
    endfunction

    function automatic logic is_gpr(input t_byte idx);
        return (idx >= REG_GPR_FIRST) && (idx <= REG_GPR_LAST);
    endfunction

    function automatic logic [GPR_IDX_W-1:0] gpr_index(input t_byte idx);
        return GPR_IDX_W'(idx - REG_GPR_FIRST);
    endfunction

    // architectural register read; out of range indexes read zero
    function automatic t_byte reg_value(input t_byte idx, input t_byte pc, input t_byte sp,
                                        input t_byte acc, input t_byte flag,
                                        input t_byte gq, input logic gvld);
        t_byte v;
        priority if (idx == REG_PC)   v = pc;
        else if (idx == REG_SP)       v = sp;
        else if (is_gpr(idx))         v = gvld ? gq : '0;
        else if (idx == REG_ACC)      v = acc;
        else if (idx == REG_FLAG)     v = flag;
        else                          v = '0;
        return v;
    endfunction

    // state registers
    t_state                r_state, n_state;
    t_byte                 r_pc, n_pc;
    t_byte                 r_sp, n_sp;
    t_byte                 r_acc, n_acc;
    t_byte                 r_flag, n_flag;
    logic                  r_halt, n_halt;
    t_byte                 r_base;
    logic [AW-1:0]         r_clr_addr;
    logic [GPR_DEPTH-1:0]  r_gpr_vld;

    // fetched instruction
    t_byte                 r_op, r_a0, r_a1;

    // pending result stage
    logic                  r_pnd_vld, n_pnd_vld;
    t_func                 r_pnd_func, n_pnd_func;
    t_byte                 r_pnd_op, n_pnd_op;
    t_byte                 r_pnd_idx, n_pnd_idx;

    // output register
    logic                  r_out_vld;
    t_byte                 r_out_rdata, r_out_pc, r_out_sp, r_out_acc, r_out_op;
    logic [FLAG_W-1:0]     r_out_flag;
    logic                  r_out_halt;

    // data memory port
    t_byte                 mem [MEM_DEPTH];
    t_byte                 r_mem_q;
    logic                  m_we, m_re;
    logic [AW-1:0]         m_addr;
    t_byte                 m_wdata;

    // general register memory ports
    t_byte                 gpr [GPR_DEPTH];
    t_byte                 r_gpr_qa, r_gpr_qb;
    logic                  r_qa_vld, r_qb_vld;
    logic                  ga_re, gb_re, gw_en;
    logic [GPR_IDX_W-1:0]  ga_idx, gb_idx, gw_idx;
    t_byte                 gw_data;

    // handshake
    logic                  out_free, pnd_drain, item_ready, item_acc;
    t_byte                 rd_idx;

    assign out_free   = !r_out_vld || o_result.ready;
    assign pnd_drain  = r_pnd_vld && out_free;
    assign item_ready = (r_state == ST_IDLE) && (!r_pnd_vld || out_free);
    assign item_acc   = i_item.valid && item_ready;
    assign rd_idx     = i_item.address[ADDR_W-1] ? REG_NONE : i_item.address[BYTE_W-1:0];

    // next state, memory control and execution
    always_comb begin
        logic [AW-1:0]      fetch_base;
        t_byte              pc3, ra0, ra1;
        logic [2*BYTE_W-1:0] prod;
        logic               rw_en;
        t_byte              rw_idx, rw_val;

        fetch_base = wrap_addr(SUM_W'(r_base) + SUM_W'(r_pc));
        pc3  = t_byte'(r_pc + t_byte'(PC_STEP));
        ra0  = reg_value(r_a0, pc3, r_sp, r_acc, r_flag, r_gpr_qa, r_qa_vld);
        ra1  = reg_value(r_a1, pc3, r_sp, r_acc, r_flag, r_gpr_qb, r_qb_vld);
        prod = (2*BYTE_W)'(ra1) * (2*BYTE_W)'(ra0);

        n_state    = r_state;
        n_pc       = r_pc;
        n_sp       = r_sp;
        n_acc      = r_acc;
        n_flag     = r_flag;
        n_halt     = r_halt;
        n_pnd_vld  = r_pnd_vld && !out_free;
        n_pnd_func = r_pnd_func;
        n_pnd_op   = r_pnd_op;
        n_pnd_idx  = r_pnd_idx;
        m_we       = 1'b0;
        m_re       = 1'b0;
        m_addr     = r_clr_addr;
        m_wdata    = '0;
        ga_re      = 1'b0;
        ga_idx     = gpr_index(rd_idx);
        gb_re      = 1'b0;
        gb_idx     = gpr_index(r_mem_q);
        gw_en      = 1'b0;
        gw_idx     = gpr_index(r_a0);
        gw_data    = '0;
        rw_en      = 1'b0;
        rw_idx     = r_a0;
        rw_val     = '0;

        unique case (r_state)
            ST_CLEAR: begin
                m_we   = 1'b1;
                m_addr = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (item_acc) begin
                    n_pnd_func = i_item.func;
                    n_pnd_op   = OP_NOP;
                    n_pnd_idx  = rd_idx;
                    unique case (i_item.func)
                        FUNC_WRITE_MEM: begin
                            m_we      = 1'b1;
                            m_addr    = wrap_addr(SUM_W'(i_item.address));
                            m_wdata   = i_item.data;
                            n_pnd_vld = 1'b1;
                        end
                        FUNC_READ_MEM: begin
                            m_re      = 1'b1;
                            m_addr    = wrap_addr(SUM_W'(i_item.address));
                            n_pnd_vld = 1'b1;
                        end
                        FUNC_READ_REG: begin
                            ga_re     = 1'b1;
                            n_pnd_vld = 1'b1;
                        end
                        FUNC_STEP: begin
                            if (r_halt) begin
                                n_pnd_vld = 1'b1;
                            end else begin
                                m_re    = 1'b1;
                                m_addr  = fetch_base;
                                n_state = ST_FETCH1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH1: begin
                m_re    = 1'b1;
                m_addr  = wrap_addr(SUM_W'(r_base) + SUM_W'(r_pc) + SUM_W'(1));
                n_state = ST_FETCH2;
            end
            ST_FETCH2: begin
                m_re    = 1'b1;
                m_addr  = wrap_addr(SUM_W'(r_base) + SUM_W'(r_pc) + SUM_W'(2));
                ga_re   = 1'b1;
                ga_idx  = gpr_index(r_mem_q);
                n_state = ST_FETCH3;
            end
            ST_FETCH3: begin
                gb_re   = 1'b1;
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_pc       = pc3;
                n_state    = ST_IDLE;
                n_pnd_vld  = 1'b1;
                n_pnd_func = FUNC_STEP;
                n_pnd_op   = r_op;
                unique case (r_op)
                    OP_COPY: begin
                        rw_en  = 1'b1;
                        rw_val = ra1;
                    end
                    OP_STORE: begin
                        m_we    = 1'b1;
                        m_addr  = AW'(ra0);
                        m_wdata = ra1;
                    end
                    OP_LOAD: begin
                        m_re      = 1'b1;
                        m_addr    = AW'(ra0);
                        n_state   = ST_WBACK;
                        n_pnd_vld = 1'b0;
                    end
                    OP_IMM: begin
                        rw_en  = 1'b1;
                        rw_val = r_a1;
                    end
                    OP_INC: begin
                        rw_en  = 1'b1;
                        rw_val = t_byte'(ra0 + 8'd1);
                    end
                    OP_DEC: begin
                        rw_en  = 1'b1;
                        rw_val = t_byte'(ra0 - 8'd1);
                    end
                    OP_ADD: n_acc = t_byte'(ra1 + ra0);
                    OP_SUB: n_acc = t_byte'(ra1 - ra0);
                    OP_MUL: n_acc = prod[BYTE_W-1:0];
                    OP_PUSH: begin
                        m_we    = 1'b1;
                        m_addr  = AW'(r_sp);
                        m_wdata = ra0;
                        n_sp    = t_byte'(r_sp + 8'd1);
                    end
                    OP_POP, OP_RET: begin
                        n_sp      = t_byte'(r_sp - 8'd1);
                        m_re      = 1'b1;
                        m_addr    = AW'(t_byte'(r_sp - 8'd1));
                        n_state   = ST_WBACK;
                        n_pnd_vld = 1'b0;
                    end
                    OP_CALL: begin
                        m_we    = 1'b1;
                        m_addr  = AW'(r_sp);
                        m_wdata = pc3;
                        n_sp    = t_byte'(r_sp + 8'd1);
                        n_pc    = r_a0;
                    end
                    OP_RCALL: begin
                        m_we    = 1'b1;
                        m_addr  = AW'(r_sp);
                        m_wdata = pc3;
                        n_sp    = t_byte'(r_sp + 8'd1);
                        // target sees the stack pointer already bumped
                        n_pc    = (r_a0 == REG_SP) ? t_byte'(r_sp + 8'd1) : ra0;
                    end
                    OP_CMP: n_flag = (ra0 > ra1) ? FLAG_GT : ((ra0 < ra1) ? FLAG_LT : FLAG_EQ);
                    OP_JMP: n_pc = r_a0;
                    OP_JEQ: if (r_flag == FLAG_EQ) n_pc = r_a0;
                    OP_JLT: if (r_flag == FLAG_LT) n_pc = r_a0;
                    OP_JGT: if (r_flag == FLAG_GT) n_pc = r_a0;
                    OP_JNE: if (r_flag != FLAG_EQ) n_pc = r_a0;
                    OP_HALT: n_halt = 1'b1;
                    default: ;
                endcase
            end
            ST_WBACK: begin
                n_state    = ST_IDLE;
                n_pnd_vld  = 1'b1;
                n_pnd_func = FUNC_STEP;
                n_pnd_op   = r_op;
                priority if (r_op == OP_LOAD) begin
                    rw_en  = 1'b1;
                    rw_idx = r_a1;
                    rw_val = r_mem_q;
                end else if (r_op == OP_POP) begin
                    rw_en  = 1'b1;
                    rw_val = r_mem_q;
                end else begin
                    n_pc = r_mem_q;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // register write from an instruction; out of range indexes are dropped
        if (rw_en) begin
            priority if (rw_idx == REG_PC) begin
                n_pc = rw_val;
            end else if (rw_idx == REG_SP) begin
                n_sp = rw_val;
            end else if (is_gpr(rw_idx)) begin
                gw_en   = 1'b1;
                gw_idx  = gpr_index(rw_idx);
                gw_data = rw_val;
            end else if (rw_idx == REG_ACC) begin
                n_acc = rw_val;
            end else if (rw_idx == REG_FLAG) begin
                n_flag = rw_val;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_pc       <= '0;
            r_sp       <= '0;
            r_acc      <= '0;
            r_flag     <= '0;
            r_halt     <= 1'b0;
            r_base     <= t_byte'(BASE_RESET);
            r_clr_addr <= '0;
            r_gpr_vld  <= '0;
            r_pnd_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_sp      <= n_sp;
            r_acc     <= n_acc;
            r_flag    <= n_flag;
            r_halt    <= n_halt;
            r_pnd_vld <= n_pnd_vld;
            if (i_cfg_wr_en) r_base <= i_cfg_wr_data;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (gw_en) r_gpr_vld[gw_idx] <= 1'b1;
            if (pnd_drain) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // instruction bytes, pending word and read validity
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FETCH1) r_op <= r_mem_q;
        if (r_state == ST_FETCH2) r_a0 <= r_mem_q;
        if (r_state == ST_FETCH3) r_a1 <= r_mem_q;
        if (ga_re) r_qa_vld <= r_gpr_vld[ga_idx];
        if (gb_re) r_qb_vld <= r_gpr_vld[gb_idx];
        r_pnd_func <= n_pnd_func;
        r_pnd_op   <= n_pnd_op;
        r_pnd_idx  <= n_pnd_idx;
    end

    // result word formed from the state left by the item
    always_ff @(posedge i_clk) begin
        if (pnd_drain) begin
            unique case (r_pnd_func)
                FUNC_READ_REG: r_out_rdata <= reg_value(r_pnd_idx, r_pc, r_sp, r_acc, r_flag,
                                                        r_gpr_qa, r_qa_vld);
                FUNC_READ_MEM: r_out_rdata <= r_mem_q;
                default:       r_out_rdata <= '0;
            endcase
            r_out_pc   <= r_pc;
            r_out_sp   <= r_sp;
            r_out_acc  <= r_acc;
            r_out_flag <= r_flag[FLAG_W-1:0];
            r_out_op   <= r_pnd_op;
            r_out_halt <= r_halt;
        end
    end

    // data memory, single port
    always_ff @(posedge i_clk) begin
        if (m_we) mem[m_addr] <= m_wdata;
        if (m_re) r_mem_q <= mem[m_addr];
    end

    // general register memory, one write and two read ports
    always_ff @(posedge i_clk) begin
        if (gw_en) gpr[gw_idx] <= gw_data;
        if (ga_re) r_gpr_qa <= gpr[ga_idx];
        if (gb_re) r_gpr_qb <= gpr[gb_idx];
    end

    // ports
    assign i_item.ready          = item_ready;
    assign o_result.valid        = r_out_vld;
    assign o_result.read_data    = r_out_rdata;
    assign o_result.pc_value     = r_out_pc;
    assign o_result.sp_value     = r_out_sp;
    assign o_result.accumulator  = r_out_acc;
    assign o_result.compare_flag = r_out_flag;
    assign o_result.opcode_done  = r_out_op;
    assign o_result.halted       = r_out_halt;

`ifndef SYNTH
    // a step only executes once the previous result has left the pending stage
    a_exec_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC || r_state == ST_WBACK) |-> !r_pnd_vld)
        else $error("step executing with a pending result");

    // nothing is taken while the memory is being cleared
    a_clear_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !item_ready)
        else $error("word accepted during clearing pass");

    // halt only leaves through reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_halt))
        else $error("halt flag dropped without reset");

    // a step while halted leaves the machine state alone
    a_halted_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && i_item.func == FUNC_STEP && r_halt) |=>
        (r_pc == $past(r_pc) && r_sp == $past(r_sp) && r_acc == $past(r_acc)))
        else $error("halted step changed state");

    // compare leaves one of the three flag codes
    a_flag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_op == OP_CMP) |=>
        (r_flag == FLAG_EQ || r_flag == FLAG_GT || r_flag == FLAG_LT))
        else $error("compare gave an unknown flag");
`endif

endmodule

/* tb/byte_cpu_fetch_execute_core_tb.sv */
// testbench: byte processor core checked word by word against an in-bench instruction predictor
module byte_cpu_fetch_execute_core_tb;
    import bcpu_pkg::*;

    localparam int MEM_DEPTH = 512;
    localparam int NUM_REGS  = int'(REG_FLAG) + 1;
    localparam int HOLD_LEN  = 300;

    typedef struct packed {
        t_func              func;
        logic [ADDR_W-1:0]  address;
        t_byte              data;
    } t_cpu_word;

    typedef struct packed {
        t_byte              read_data;
        t_byte              pc_value;
        t_byte              sp_value;
        t_byte              accumulator;
        logic [FLAG_W-1:0]  compare_flag;
        t_byte              opcode_done;
        logic               halted;
    } t_cpu_result;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    t_byte cfg_wr_data;

    bcpu_item_if   item_if ();
    bcpu_result_if res_if ();

    byte_cpu_fetch_execute_core #(.MEM_DEPTH(MEM_DEPTH)) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (item_if.sink),
        .o_result      (res_if.source)
    );

    // predicted processor state
    t_byte cpu_regs [NUM_REGS];
    t_byte cpu_mem [MEM_DEPTH];
    logic  cpu_halted = 1'b0;
    t_byte cpu_base = t_byte'(BASE_RESET);
    bit    op_seen [256];
    int    steps_run = 0;

    t_cpu_word   pending_words[$];
    t_cpu_result expected_results[$];

    int mismatches   = 0;
    int words_queued = 0;
    int results_seen = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_cnt     = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;

    // register access, indexes above the flag register read zero and drop writes
    function automatic t_byte reg_get(t_byte idx);
        return (idx <= REG_FLAG) ? cpu_regs[idx[3:0]] : '0;
    endfunction

    function automatic void reg_put(t_byte idx, t_byte v);
        if (idx <= REG_FLAG) begin
            cpu_regs[idx[3:0]] = v;
        end
    endfunction

    function automatic void stack_push(t_byte v);
        cpu_mem[cpu_regs[REG_SP]] = v;
        cpu_regs[REG_SP] = cpu_regs[REG_SP] + 8'd1;
    endfunction

    // pop decrements first, then reads
    function automatic t_byte stack_pop();
        cpu_regs[REG_SP] = cpu_regs[REG_SP] - 8'd1;
        return cpu_mem[cpu_regs[REG_SP]];
    endfunction

    // fetch three bytes, advance pc, execute
    function automatic t_byte cpu_step();
        int at;
        t_byte op, a0, a1, flag;
        at = int'(cpu_base) + int'(cpu_regs[REG_PC]);
        op = cpu_mem[at % MEM_DEPTH];
        a0 = cpu_mem[(at + 1) % MEM_DEPTH];
        a1 = cpu_mem[(at + 2) % MEM_DEPTH];
        cpu_regs[REG_PC] = cpu_regs[REG_PC] + t_byte'(PC_STEP);
        flag = cpu_regs[REG_FLAG];
        case (op)
            OP_COPY:  reg_put(a0, reg_get(a1));
            OP_STORE: cpu_mem[reg_get(a0)] = reg_get(a1);
            OP_LOAD:  reg_put(a1, cpu_mem[reg_get(a0)]);
            OP_IMM:   reg_put(a0, a1);
            OP_INC:   reg_put(a0, reg_get(a0) + 8'd1);
            OP_DEC:   reg_put(a0, reg_get(a0) - 8'd1);
            OP_ADD:   cpu_regs[REG_ACC] = reg_get(a1) + reg_get(a0);
            OP_SUB:   cpu_regs[REG_ACC] = reg_get(a1) - reg_get(a0);
            OP_MUL:   cpu_regs[REG_ACC] = reg_get(a1) * reg_get(a0);
            OP_PUSH:  stack_push(reg_get(a0));
            OP_POP:   reg_put(a0, stack_pop());
            OP_CALL: begin
                stack_push(cpu_regs[REG_PC]);
                cpu_regs[REG_PC] = a0;
            end
            OP_RCALL: begin
                // target read after sp has moved
                stack_push(cpu_regs[REG_PC]);
                cpu_regs[REG_PC] = reg_get(a0);
            end
            OP_RET:   cpu_regs[REG_PC] = stack_pop();
            OP_CMP: begin
                if (reg_get(a0) > reg_get(a1)) begin
                    cpu_regs[REG_FLAG] = FLAG_GT;
                end else if (reg_get(a0) < reg_get(a1)) begin
                    cpu_regs[REG_FLAG] = FLAG_LT;
                end else begin
                    cpu_regs[REG_FLAG] = FLAG_EQ;
                end
            end
            // conditional jumps test the whole flag register
            OP_JMP:   cpu_regs[REG_PC] = a0;
            OP_JEQ:   if (flag == FLAG_EQ) cpu_regs[REG_PC] = a0;
            OP_JLT:   if (flag == FLAG_LT) cpu_regs[REG_PC] = a0;
            OP_JGT:   if (flag == FLAG_GT) cpu_regs[REG_PC] = a0;
            OP_JNE:   if (flag != FLAG_EQ) cpu_regs[REG_PC] = a0;
            OP_HALT:  cpu_halted = 1'b1;
            // divide, in, out and unknown codes do nothing
            default: ;
        endcase
        op_seen[op] = 1'b1;
        steps_run++;
        return op;
    endfunction

    // apply one accepted word to the predicted state, give its result word
    function automatic t_cpu_result cpu_execute_word(t_cpu_word w);
        t_byte rd, done;
        rd   = '0;
        done = '0;
        case (w.func)
            FUNC_WRITE_MEM: cpu_mem[w.address] = w.data;
            FUNC_STEP:      if (!cpu_halted) done = cpu_step();
            FUNC_READ_REG:  if (w.address <= REG_FLAG) rd = cpu_regs[w.address[3:0]];
            FUNC_READ_MEM:  rd = cpu_mem[w.address];
            default: ;
        endcase
        return '{read_data: rd, pc_value: cpu_regs[REG_PC], sp_value: cpu_regs[REG_SP],
                 accumulator: cpu_regs[REG_ACC],
                 compare_flag: cpu_regs[REG_FLAG][FLAG_W-1:0],
                 opcode_done: done, halted: cpu_halted};
    endfunction

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // word driver: predicts on acceptance, holds a word until taken
    always @(posedge clk) begin : word_driver
        t_cpu_word w;
        if (!rst_n) begin
            item_if.valid   <= 1'b0;
            item_if.func    <= FUNC_WRITE_MEM;
            item_if.address <= '0;
            item_if.data    <= '0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                w = pending_words.pop_front();
                expected_results.push_back(cpu_execute_word(w));
            end
            if (!(item_if.valid && !item_if.ready)) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    item_if.valid   <= 1'b1;
                    item_if.func    <= pending_words[0].func;
                    item_if.address <= pending_words[0].address;
                    item_if.data    <= pending_words[0].data;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_toggle != hold_seen) begin
            hold_cnt  <= HOLD_LEN;
            hold_seen <= hold_toggle;
        end
    end

    // result monitor
    always @(posedge clk) begin : result_monitor
        t_cpu_result got, want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = '{read_data: res_if.read_data, pc_value: res_if.pc_value,
                        sp_value: res_if.sp_value, accumulator: res_if.accumulator,
                        compare_flag: res_if.compare_flag, opcode_done: res_if.opcode_done,
                        halted: res_if.halted};
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result word %0d arrived with nothing expected", results_seen);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("word %0d exp rd=%h pc=%h sp=%h acc=%h flag=%0d op=%h halt=%0d",
                                     results_seen, want.read_data, want.pc_value, want.sp_value,
                                     want.accumulator, want.compare_flag, want.opcode_done,
                                     want.halted);
                            $display("word %0d got rd=%h pc=%h sp=%h acc=%h flag=%0d op=%h halt=%0d",
                                     results_seen, got.read_data, got.pc_value, got.sp_value,
                                     got.accumulator, got.compare_flag, got.opcode_done,
                                     got.halted);
                        end
                    end
                end
            end
            res_if.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic queue_word(t_func f, int a, t_byte d);
        pending_words.push_back('{func: f, address: ADDR_W'(a), data: d});
        words_queued++;
    endtask

    // every queued word taken, so the predicted state is current
    task automatic wait_accepted();
        while (pending_words.size() != 0) @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_results.size() != 0) @(negedge clk);
    endtask

    task automatic set_base(t_byte v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cpu_base = v;
        @(negedge clk);
    endtask

    // three memory words holding one instruction at program address pc
    task automatic put_instr(t_byte pc, t_byte op, t_byte a0, t_byte a1);
        int at;
        at = int'(cpu_base) + int'(pc);
        queue_word(FUNC_WRITE_MEM, (at) % MEM_DEPTH, op);
        queue_word(FUNC_WRITE_MEM, (at + 1) % MEM_DEPTH, a0);
        queue_word(FUNC_WRITE_MEM, (at + 2) % MEM_DEPTH, a1);
    endtask

    // step, first overwriting a halt that random data left at the fetch address
    task automatic step_checked();
        int at;
        wait_accepted();
        at = (int'(cpu_base) + int'(cpu_regs[REG_PC])) % MEM_DEPTH;
        if (cpu_mem[at] == OP_HALT) begin
            queue_word(FUNC_WRITE_MEM, at, OP_NOP);
        end
        queue_word(FUNC_STEP, $urandom_range(0, MEM_DEPTH - 1), t_byte'($urandom));
    endtask

    function automatic t_byte reg_operand();
        return ($urandom_range(0, 9) == 0) ? t_byte'($urandom) : t_byte'($urandom_range(0, 11));
    endfunction

    // random instruction, never a halt; jump targets often land inside the segment
    task automatic pick_instr(input t_byte seg_pc, input int k,
                              output t_byte op, output t_byte a0, output t_byte a1);
        if ($urandom_range(0, 6) == 0) begin
            op = t_byte'($urandom_range(25, 255));
        end else begin
            do op = t_byte'($urandom_range(0, int'(OP_IN))); while (op == OP_HALT);
        end
        a0 = reg_operand();
        a1 = (op == OP_IMM) ? t_byte'($urandom) : reg_operand();
        case (op)
            OP_CALL, OP_JMP, OP_JEQ, OP_JLT, OP_JGT, OP_JNE: begin
                if ($urandom_range(0, 1) == 0) begin
                    a0 = t_byte'(int'(seg_pc) + 3 * $urandom_range(0, k));
                end else begin
                    a0 = t_byte'($urandom);
                end
            end
            default: ;
        endcase
    endtask

    task automatic noise_word();
        t_func f;
        f = t_func'($urandom_range(0, 3));
        if (f == FUNC_STEP) begin
            step_checked();
        end else if (f == FUNC_READ_REG && $urandom_range(0, 1) == 0) begin
            queue_word(f, $urandom_range(0, 15), t_byte'($urandom));
        end else begin
            queue_word(f, $urandom_range(0, MEM_DEPTH - 1), t_byte'($urandom));
        end
    endtask

    // a short program written at the current pc and then stepped through
    task automatic run_segment();
        t_byte seg_pc, op, a0, a1;
        int k, n;
        wait_accepted();
        seg_pc = cpu_regs[REG_PC];
        k = $urandom_range(1, 6);
        for (int j = 0; j < k; j++) begin
            pick_instr(seg_pc, k, op, a0, a1);
            put_instr(t_byte'(int'(seg_pc) + 3 * j), op, a0, a1);
            if ($urandom_range(0, 7) == 0) noise_word();
        end
        n = k + $urandom_range(0, 2);
        for (int j = 0; j < n; j++) begin
            step_checked();
            if ($urandom_range(0, 5) == 0) noise_word();
        end
    endtask

    task automatic run_phase(int n);
        int stop_at;
        stop_at = words_queued + n;
        while (words_queued < stop_at) begin
            if ($urandom_range(0, 4) == 0) noise_word();
            else run_segment();
        end
    endtask

    // stimulus
    initial begin : stimulus
        t_byte mid_base;
        int distinct_ops;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        foreach (cpu_regs[i]) cpu_regs[i] = '0;
        foreach (cpu_mem[i]) cpu_mem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, register index limits, flag above two, unknown code
        snd_idle_pct = 31;
        rcv_idle_pct = 55;
        queue_word(FUNC_WRITE_MEM, MEM_DEPTH - 1, 8'hFF);
        queue_word(FUNC_READ_MEM, MEM_DEPTH - 1, 8'h00);
        queue_word(FUNC_READ_MEM, 0, 8'hFF);
        queue_word(FUNC_READ_REG, int'(REG_PC), 8'h00);
        queue_word(FUNC_READ_REG, int'(REG_FLAG), 8'h00);
        queue_word(FUNC_READ_REG, 12, 8'h00);
        queue_word(FUNC_READ_REG, MEM_DEPTH - 1, 8'h00);
        put_instr(8'd0, OP_IMM, REG_FLAG, 8'd7);
        step_checked();
        put_instr(8'd3, OP_JNE, 8'd30, 8'd0);
        step_checked();
        put_instr(8'd30, OP_IMM, 8'd12, 8'd99);
        step_checked();
        queue_word(FUNC_WRITE_MEM, int'(cpu_base) + 33, 8'hFF);
        step_checked();
        queue_word(FUNC_READ_REG, int'(REG_FLAG), 8'hA5);

        // sender idles less than the receiver
        run_phase(500);

        // swapped idling, base at its low extreme
        wait_idle();
        set_base(8'd0);
        snd_idle_pct = 55;
        rcv_idle_pct = 31;
        run_phase(500);

        // no idling, base at its high extreme so fetches wrap; long receiver stall first
        wait_idle();
        set_base(8'hFF);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_toggle = ~hold_toggle;
        for (int j = 0; j < 40; j++) begin
            t_func f;
            f = t_func'($urandom_range(0, 2));
            if (f == FUNC_STEP) f = FUNC_READ_MEM;
            queue_word(f, $urandom_range(0, MEM_DEPTH - 1), t_byte'($urandom));
        end
        run_phase(310);

        wait_idle();
        mid_base = t_byte'($urandom_range(1, 254));
        set_base(mid_base);
        run_phase(200);

        // halt, then steps that do nothing and memory access still served
        wait_accepted();
        put_instr(cpu_regs[REG_PC], OP_HALT, t_byte'($urandom), t_byte'($urandom));
        queue_word(FUNC_STEP, 0, 8'h00);
        queue_word(FUNC_STEP, MEM_DEPTH - 1, 8'hFF);
        queue_word(FUNC_WRITE_MEM, 300, 8'h3C);
        queue_word(FUNC_READ_MEM, 300, 8'h00);
        queue_word(FUNC_READ_REG, int'(REG_PC), 8'h00);

        wait_idle();
        repeat (20) @(posedge clk);
        distinct_ops = 0;
        foreach (op_seen[i]) if (op_seen[i]) distinct_ops++;
        $display("run covered %0d words and %0d steps over %0d distinct opcodes",
                 words_queued, steps_run, distinct_ops);
        $display("program bases 8, 0, 255 and %0d, one %0d cycle receiver stall, %0d mismatches",
                 mid_base, HOLD_LEN, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bcpu_pkg.sv
rtl/bcpu_item_if.sv
rtl/bcpu_result_if.sv
rtl/byte_cpu_fetch_execute_core.sv
tb/byte_cpu_fetch_execute_core_tb.sv
